### hdl/fit_policy_block_allocator_unit_macros.svh
// Assertion macros for the checker file of the block allocator.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define FPBA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("fpba assertion failed");

// Implication: when the condition holds, the consequence holds in the following cycle.
`define FPBA_ASSERT_NEXT(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("fpba assertion failed");

`endif

### hdl/fpba_pkg.sv
// Package of types and constants for the block allocator.
package fpba_pkg;

   localparam int NUM_BLOCKS = 8;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_BITS   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int COUNT_BITS = 4;
   localparam int STATUS_BITS = 2;
   localparam int POLICY_BITS = 2;

   localparam logic [COUNT_BITS-1:0] NUM_BLOCKS_CNT = COUNT_BITS'(NUM_BLOCKS);

   localparam logic [STATUS_BITS-1:0] STATUS_LOADED    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ALLOCATED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_ALLOC = 2'd2;

   localparam logic [POLICY_BITS-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_BITS-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_BITS-1:0] POLICY_WORST = 2'd2;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_ALLOC = 1'b1;

   localparam logic CSR_FIT_POLICY    = 1'b0;
   localparam logic CSR_BLOCKS_IN_USE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                   clear;
      logic                   eval;
      logic [POLICY_BITS-1:0] policy;
   } pick_ctrl_type;

endpackage

### hdl/fpba_pick.sv
// Running selection of the fitting table entry during an allocation scan.
module fpba_pick (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fpba_pkg::pick_ctrl_type               ctrl,
   input  logic [fpba_pkg::SIZE_BITS-1:0]        req_size,
   input  logic [fpba_pkg::SIZE_BITS-1:0]        entry_size,
   input  logic [fpba_pkg::IDX_BITS-1:0]         entry_idx,
   output logic                                  found,
   output logic [fpba_pkg::IDX_BITS-1:0]         sel_idx,
   output logic [fpba_pkg::SIZE_BITS-1:0]        sel_size
);

   logic                              found_ff, found_in;
   logic [fpba_pkg::IDX_BITS-1:0]     sel_idx_ff, sel_idx_in;
   logic [fpba_pkg::SIZE_BITS-1:0]    sel_size_ff, sel_size_in;
   logic                              fits;
   logic                              take;

   always_comb begin
      fits = (entry_size >= req_size);
      // Strict compares keep the lowest index on ties; any other policy code stays with the first hit.
      take = fits && (!found_ff ||
                      ((ctrl.policy == fpba_pkg::POLICY_BEST)  && (entry_size < sel_size_ff)) ||
                      ((ctrl.policy == fpba_pkg::POLICY_WORST) && (entry_size > sel_size_ff)));
      found_in    = found_ff;
      sel_idx_in  = sel_idx_ff;
      sel_size_in = sel_size_ff;
      priority if (ctrl.clear) begin
         found_in = 1'b0;
      end else if (ctrl.eval && take) begin
         found_in    = 1'b1;
         sel_idx_in  = entry_idx;
         sel_size_in = entry_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_idx_ff  <= sel_idx_in;
      sel_size_ff <= sel_size_in;
   end

   assign found    = found_ff;
   assign sel_idx  = sel_idx_ff;
   assign sel_size = sel_size_ff;

endmodule

### hdl/fit_policy_block_allocator_unit.sv
// Channel | direction | handshake                | payload
// req     | in        | req_valid / req_stall    | req_type, req_block_index, req_size_value
// rsp     | out       | rsp_valid / rsp_stall    | rsp_status, rsp_chosen_block, rsp_remaining_size
// csr     | in        | csr_valid / csr_ready    | csr_index, csr_data
//
// A load item writes its entry; an allocate item scans the first min(blocks_in_use, 8) entries
// through the single read port of the free-size memory, one entry a cycle, and writes back the
// remainder if one fits. The result goes from the done state to the output register, and the
// next item is taken in the idle state after that. req_stall is high from acceptance until
// then, so a held result keeps the next item in its done state. Synchronous reset clears the
// control state and the per-entry valid bits, so every entry reads as zero with no clearing pass.
module fit_policy_block_allocator_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_type,
   input  logic [fpba_pkg::IDX_BITS-1:0]           req_block_index,
   input  logic [fpba_pkg::SIZE_BITS-1:0]          req_size_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [fpba_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic [fpba_pkg::IDX_BITS-1:0]           rsp_chosen_block,
   output logic [fpba_pkg::SIZE_BITS-1:0]          rsp_remaining_size,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic                                    csr_index,
   input  logic [fpba_pkg::COUNT_BITS-1:0]         csr_data
);

   fpba_pkg::state_type                    state_ff, state_in;
   logic [fpba_pkg::POLICY_BITS-1:0]       fit_policy_ff;
   logic [fpba_pkg::COUNT_BITS-1:0]        blocks_in_use_ff;
   logic [fpba_pkg::COUNT_BITS-1:0]        limit;
   logic [fpba_pkg::COUNT_BITS-1:0]        iss_ff, iss_in;
   logic                                   rd_pending_ff, rd_pending_in;
   logic [fpba_pkg::IDX_BITS-1:0]          rd_idx_ff;
   logic [fpba_pkg::IDX_BITS-1:0]          rd_addr;
   logic [fpba_pkg::SIZE_BITS-1:0]         rd_data_ff;
   logic [fpba_pkg::SIZE_BITS-1:0]         entry_size;
   logic [fpba_pkg::SIZE_BITS-1:0]         req_size_ff, req_size_in;
   logic [fpba_pkg::NUM_BLOCKS-1:0]        valid_ff;
   logic                                   wr_en;
   logic [fpba_pkg::IDX_BITS-1:0]          wr_addr;
   logic [fpba_pkg::SIZE_BITS-1:0]         wr_data;
   logic [fpba_pkg::SIZE_BITS-1:0]         remain;
   logic [fpba_pkg::STATUS_BITS-1:0]       res_status_ff, res_status_in;
   logic [fpba_pkg::IDX_BITS-1:0]          res_block_ff, res_block_in;
   logic [fpba_pkg::SIZE_BITS-1:0]         res_size_ff, res_size_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic                                   rsp_load;
   logic [fpba_pkg::STATUS_BITS-1:0]       rsp_status_ff;
   logic [fpba_pkg::IDX_BITS-1:0]          rsp_block_ff;
   logic [fpba_pkg::SIZE_BITS-1:0]         rsp_size_ff;
   fpba_pkg::pick_ctrl_type                pick_ctrl;
   logic                                   pick_found;
   logic [fpba_pkg::IDX_BITS-1:0]          pick_idx;
   logic [fpba_pkg::SIZE_BITS-1:0]         pick_size;

   logic [fpba_pkg::SIZE_BITS-1:0]         free_mem [fpba_pkg::NUM_BLOCKS];

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff    <= fpba_pkg::POLICY_FIRST;
         blocks_in_use_ff <= fpba_pkg::NUM_BLOCKS_CNT;
      end else if (csr_valid) begin
         unique case (csr_index)
            fpba_pkg::CSR_FIT_POLICY:    fit_policy_ff    <= csr_data[fpba_pkg::POLICY_BITS-1:0];
            fpba_pkg::CSR_BLOCKS_IN_USE: blocks_in_use_ff <= csr_data;
            default:                     fit_policy_ff    <= fit_policy_ff;
         endcase
      end
   end

   assign limit = (blocks_in_use_ff > fpba_pkg::NUM_BLOCKS_CNT) ? fpba_pkg::NUM_BLOCKS_CNT
                                                                 : blocks_in_use_ff;

   // Free-size memory: one write port, one read port with registered data.
   assign rd_addr = iss_ff[fpba_pkg::IDX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         free_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= free_mem[rd_addr];
      rd_idx_ff  <= rd_addr;
   end

   // An entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign entry_size = valid_ff[rd_idx_ff] ? rd_data_ff : '0;
   assign remain     = pick_size - req_size_ff;

   fpba_pick u_pick (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (pick_ctrl),
      .req_size   (req_size_ff),
      .entry_size (entry_size),
      .entry_idx  (rd_idx_ff),
      .found      (pick_found),
      .sel_idx    (pick_idx),
      .sel_size   (pick_size)
   );

   // Sequencer.
   always_comb begin
      state_in         = state_ff;
      iss_in           = iss_ff;
      rd_pending_in    = 1'b0;
      req_size_in      = req_size_ff;
      res_status_in    = res_status_ff;
      res_block_in     = res_block_ff;
      res_size_in      = res_size_ff;
      wr_en            = 1'b0;
      wr_addr          = req_block_index;
      wr_data          = req_size_value;
      rsp_load         = 1'b0;
      req_stall        = 1'b1;
      pick_ctrl.clear  = 1'b0;
      pick_ctrl.eval   = 1'b0;
      pick_ctrl.policy = fit_policy_ff;
      unique case (state_ff)
         fpba_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_type == fpba_pkg::REQ_LOAD) begin
                  wr_en         = 1'b1;
                  res_status_in = fpba_pkg::STATUS_LOADED;
                  res_block_in  = '0;
                  res_size_in   = '0;
                  state_in      = fpba_pkg::ST_DONE;
               end else begin
                  req_size_in     = req_size_value;
                  iss_in          = '0;
                  pick_ctrl.clear = 1'b1;
                  state_in        = fpba_pkg::ST_SCAN;
               end
            end
         end
         fpba_pkg::ST_SCAN: begin
            // Reads are issued one a cycle; each is judged when its data returns.
            pick_ctrl.eval = rd_pending_ff;
            if (iss_ff < limit) begin
               rd_pending_in = 1'b1;
               iss_in        = iss_ff + 1'b1;
            end else if (!rd_pending_ff) begin
               state_in = fpba_pkg::ST_FINISH;
            end
         end
         fpba_pkg::ST_FINISH: begin
            if (pick_found) begin
               wr_en         = 1'b1;
               wr_addr       = pick_idx;
               wr_data       = remain;
               res_status_in = fpba_pkg::STATUS_ALLOCATED;
               res_block_in  = pick_idx;
               res_size_in   = remain;
            end else begin
               res_status_in = fpba_pkg::STATUS_NOT_ALLOC;
               res_block_in  = '0;
               res_size_in   = '0;
            end
            state_in = fpba_pkg::ST_DONE;
         end
         fpba_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = fpba_pkg::ST_IDLE;
            end
         end
         default: state_in = fpba_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fpba_pkg::ST_IDLE;
         iss_ff        <= '0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         iss_ff        <= iss_in;
         rd_pending_ff <= rd_pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_size_ff   <= req_size_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      res_size_ff   <= res_size_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_block_ff  <= res_block_ff;
         rsp_size_ff   <= res_size_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_chosen_block   = rsp_block_ff;
   assign rsp_remaining_size = rsp_size_ff;

endmodule

### hdl/fpba_checker.sv
// Port-level checker for the block allocator, bound to the top level.
`include "fit_policy_block_allocator_unit_macros.svh"

module fpba_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic [fpba_pkg::STATUS_BITS-1:0]        rsp_status,
   input logic [fpba_pkg::IDX_BITS-1:0]           rsp_chosen_block,
   input logic [fpba_pkg::SIZE_BITS-1:0]          rsp_remaining_size
);

   // A stalled result holds its payload.
   `FPBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_chosen_block) && $stable(rsp_remaining_size))

   // Only one item is in work: acceptance closes the input channel for the next cycle.
   `FPBA_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && !req_stall, req_stall)

   // A fresh result only follows a cycle in which an item was in work.
   `FPBA_ASSERT(a_rsp_from_work, clock, reset, $rose(rsp_valid) |-> $past(req_stall))

   // Results that give no block carry zero in the block fields.
   `FPBA_ASSERT(a_unused_zero, clock, reset, (rsp_valid && (rsp_status != fpba_pkg::STATUS_ALLOCATED)) |-> ((rsp_chosen_block == '0) && (rsp_remaining_size == '0)))

endmodule

bind fit_policy_block_allocator_unit fpba_checker u_fpba_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_chosen_block   (rsp_chosen_block),
   .rsp_remaining_size (rsp_remaining_size)
);

### sim/fit_policy_block_allocator_unit_tb.sv
// Self-checking testbench for the first, best and worst fit block allocator.
`timescale 1ns / 100ps

module fit_policy_block_allocator_unit_tb;
   import fpba_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int TAIL_CYCLES = 16;
   localparam logic [POLICY_BITS-1:0] POLICY_SPARE = 2'd3;

   typedef struct packed {
      logic                  kind;
      logic [IDX_BITS-1:0]   index;
      logic [SIZE_BITS-1:0]  amount;
   } alloc_req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [IDX_BITS-1:0]    chosen;
      logic [SIZE_BITS-1:0]   remaining;
   } alloc_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_type = REQ_LOAD;
   logic [IDX_BITS-1:0]    req_block_index = '0;
   logic [SIZE_BITS-1:0]   req_size_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [IDX_BITS-1:0]    rsp_chosen_block;
   logic [SIZE_BITS-1:0]   rsp_remaining_size;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic                   csr_index = CSR_FIT_POLICY;
   logic [COUNT_BITS-1:0]  csr_data = '0;

   // Own copy of the allocator state and its registers.
   logic [SIZE_BITS-1:0]   free_sizes [NUM_BLOCKS];
   logic [POLICY_BITS-1:0] fit_mode = POLICY_FIRST;
   logic [COUNT_BITS-1:0]  scan_count = NUM_BLOCKS_CNT;

   alloc_req_type    req_items_q [$];
   alloc_result_type alloc_outcomes_q [$];
   alloc_result_type oldest_outcome;

   int   mismatches = 0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   quiet_cycles = 0;
   logic sender_eager = 1'b0;
   logic hold_for_drain = 1'b0;
   logic [9:0] stall_tick = '0;

   fit_policy_block_allocator_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_block_index    (req_block_index),
      .req_size_value     (req_size_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_chosen_block   (rsp_chosen_block),
      .rsp_remaining_size (rsp_remaining_size),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Loads write the table; allocations scan it under the current policy and scan count.
   function automatic alloc_result_type predict_allocation(alloc_req_type item);
      alloc_result_type    res;
      int                  span;
      logic                found;
      logic [IDX_BITS-1:0] pick;
      res = '0;
      found = 1'b0;
      pick = '0;
      span = (scan_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(scan_count);
      if (item.kind == REQ_LOAD) begin
         free_sizes[item.index] = item.amount;
         res.status = STATUS_LOADED;
      end else begin
         for (int k = 0; k < span; k++) begin
            if (free_sizes[k] >= item.amount) begin
               if (!found) begin
                  found = 1'b1;
                  pick = IDX_BITS'(k);
               end else if (fit_mode == POLICY_BEST && free_sizes[k] < free_sizes[pick]) begin
                  pick = IDX_BITS'(k);
               end else if (fit_mode == POLICY_WORST && free_sizes[k] > free_sizes[pick]) begin
                  pick = IDX_BITS'(k);
               end
            end
         end
         if (found) begin
            free_sizes[pick] = free_sizes[pick] - item.amount;
            res.status = STATUS_ALLOCATED;
            res.chosen = pick;
            res.remaining = free_sizes[pick];
         end else begin
            res.status = STATUS_NOT_ALLOC;
         end
      end
      return res;
   endfunction

   // Mix of extremes, full-range values and small sizes that keep allocations succeeding.
   function automatic logic [SIZE_BITS-1:0] draw_size(logic for_load);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return SIZE_BITS'($urandom);
         4: return for_load ? SIZE_BITS'(64 * $urandom_range(1, 3))
                            : SIZE_BITS'(32 * $urandom_range(1, 2));
         default: return for_load ? SIZE_BITS'($urandom_range(16, 300))
                                  : SIZE_BITS'($urandom_range(1, 120));
      endcase
   endfunction

   task automatic queue_item(logic kind, logic [IDX_BITS-1:0] index,
                             logic [SIZE_BITS-1:0] amount);
      alloc_req_type item;
      item.kind = kind;
      item.index = index;
      item.amount = amount;
      req_items_q.push_back(item);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (req_items_q.size() != 0 || alloc_outcomes_q.size() != 0);
   endtask

   task automatic write_csr(logic index, logic [COUNT_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_FIT_POLICY) begin
         fit_mode = data[POLICY_BITS-1:0];
      end else begin
         scan_count = data;
      end
   endtask

   // Sender: the head of the queue is presented until accepted, then popped.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            alloc_outcomes_q.push_back(predict_allocation(req_items_q.pop_front()));
            if ($urandom_range(0, 59) == 0) hold_for_drain = 1'b1;
         end
         if (hold_for_drain && alloc_outcomes_q.size() == 0) hold_for_drain = 1'b0;
         if (req_valid && req_stall) begin
            // The item stays on the port unchanged while stalled.
         end else if (req_items_q.size() == 0 || hold_for_drain) begin
            req_valid <= 1'b0;
         end else if (gap_left > 0 && !sender_eager) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_type <= req_items_q[0].kind;
            req_block_index <= req_items_q[0].index;
            req_size_value <= req_items_q[0].amount;
            if (burst_left > 0) begin
               burst_left = burst_left - 1;
            end else begin
               burst_left = $urandom_range(0, 10);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   // Receiver stall pattern: quiet, random, alternating and long runs in turn.
   always @(posedge clock) begin
      stall_tick = stall_tick + 1'b1;
      case (stall_tick[9:8])
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2'd2: rsp_stall <= stall_tick[0];
         default: rsp_stall <= (stall_tick[4:3] == 2'd0) || ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (alloc_outcomes_q.size() == 0) begin
            $error("result with no item outstanding: status %0d", rsp_status);
            mismatches++;
         end else begin
            oldest_outcome = alloc_outcomes_q.pop_front();
            if (rsp_status !== oldest_outcome.status) begin
               $error("status: expected %0d, actual %0d", oldest_outcome.status, rsp_status);
               mismatches++;
            end
            if (rsp_chosen_block !== oldest_outcome.chosen) begin
               $error("chosen_block: expected %0d, actual %0d",
                      oldest_outcome.chosen, rsp_chosen_block);
               mismatches++;
            end
            if (rsp_remaining_size !== oldest_outcome.remaining) begin
               $error("remaining_size: expected %0d, actual %0d",
                      oldest_outcome.remaining, rsp_remaining_size);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      logic [COUNT_BITS-1:0] phase_count;
      logic                  kind;
      foreach (free_sizes[k]) free_sizes[k] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // First fit over the whole table, starting from an empty table.
      queue_item(REQ_ALLOC, 3'd0, 16'd0);
      queue_item(REQ_ALLOC, 3'd7, 16'd1);
      queue_item(REQ_LOAD, 3'd0, 16'hFFFF);
      queue_item(REQ_LOAD, 3'd7, 16'h8000);
      queue_item(REQ_LOAD, 3'd3, 16'd100);
      queue_item(REQ_LOAD, 3'd5, 16'd100);
      queue_item(REQ_LOAD, 3'd1, 16'd40);
      queue_item(REQ_ALLOC, 3'd2, 16'hFFFF);
      queue_item(REQ_ALLOC, 3'd0, 16'd50);
      queue_item(REQ_ALLOC, 3'd0, 16'd0);
      queue_item(REQ_ALLOC, 3'd0, 16'h8001);
      queue_item(REQ_ALLOC, 3'd0, 16'h8000);
      wait_drained();

      // Best fit with a scan count beyond the table, including a tie on size.
      write_csr(CSR_FIT_POLICY, {2'b00, POLICY_BEST});
      write_csr(CSR_BLOCKS_IN_USE, 4'd15);
      queue_item(REQ_ALLOC, 3'd0, 16'd40);
      queue_item(REQ_LOAD, 3'd2, 16'd50);
      queue_item(REQ_ALLOC, 3'd0, 16'd45);
      queue_item(REQ_ALLOC, 3'd0, 16'd0);
      wait_drained();

      // Worst fit restricted to the first entry.
      write_csr(CSR_FIT_POLICY, {2'b00, POLICY_WORST});
      write_csr(CSR_BLOCKS_IN_USE, 4'd1);
      queue_item(REQ_LOAD, 3'd0, 16'd10);
      queue_item(REQ_ALLOC, 3'd0, 16'd5);
      queue_item(REQ_ALLOC, 3'd0, 16'd6);
      wait_drained();

      // The spare policy code acts as first fit; a scan count of zero never allocates.
      write_csr(CSR_FIT_POLICY, {2'b01, POLICY_SPARE});
      write_csr(CSR_BLOCKS_IN_USE, 4'd8);
      queue_item(REQ_ALLOC, 3'd0, 16'd5);
      wait_drained();
      write_csr(CSR_BLOCKS_IN_USE, 4'd0);
      queue_item(REQ_ALLOC, 3'd0, 16'd0);
      wait_drained();

      // Worst fit with two equal largest entries.
      write_csr(CSR_FIT_POLICY, {2'b10, POLICY_WORST});
      write_csr(CSR_BLOCKS_IN_USE, 4'd8);
      queue_item(REQ_LOAD, 3'd4, 16'd100);
      queue_item(REQ_ALLOC, 3'd0, 16'd1);
      wait_drained();

      // Random phases: each refills the table, then mixes loads and allocations.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: phase_count = 4'd8;
            3: phase_count = 4'd15;
            5: phase_count = 4'd1;
            default: phase_count = COUNT_BITS'($urandom_range(2, 8));
         endcase
         write_csr(CSR_FIT_POLICY,
                   {2'($urandom_range(0, 3)), POLICY_BITS'(phase % 4)});
         write_csr(CSR_BLOCKS_IN_USE, phase_count);
         sender_eager = (phase == 1 || phase == 6);
         for (int k = 0; k < NUM_BLOCKS; k++) begin
            queue_item(REQ_LOAD, IDX_BITS'(k), draw_size(1'b1));
         end
         for (int n = 0; n < 58; n++) begin
            kind = ($urandom_range(0, 9) < 4) ? REQ_LOAD : REQ_ALLOC;
            queue_item(kind, IDX_BITS'($urandom_range(0, NUM_BLOCKS - 1)),
                       draw_size(kind == REQ_LOAD));
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (alloc_outcomes_q.size() != 0) begin
         $error("%0d results never arrived", alloc_outcomes_q.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
